// ----- rtl/core/fcs_pkg.sv -----
// ----------------------------------------------------------------------------
// fcs_pkg
// Types, command codes and result-burst helpers of the flash command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcs_pkg;

	localparam int ADDR_BITS_DEF = 24;
	localparam int MAX_RESULTS   = 5;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W         = $clog2(MAX_RESULTS);

	localparam logic [15:0] CMD_READ_ARRAY  = 16'h00FF;
	localparam logic [15:0] CMD_ERASE_SETUP = 16'h0020;
	localparam logic [15:0] CMD_ERASE_OK    = 16'h00D0;
	localparam logic [15:0] CMD_PGM_SETUP   = 16'h0040;
	localparam logic [15:0] CMD_STATUS_READ = 16'h0070;
	localparam logic [15:0] CMD_STATUS_CLR  = 16'h0050;
	localparam logic [15:0] CMD_CFG_SETUP   = 16'h0060;
	localparam logic [15:0] CMD_LOCK        = 16'h0001;
	localparam logic [15:0] CMD_UNLOCK      = 16'h00D0;
	localparam logic [15:0] CMD_READ_CFG    = 16'h0090;
	localparam logic [15:0] ERASED_HALF     = 16'hFFFF;

	localparam int ST_READY_BIT     = 7;
	localparam int ST_ERASE_ERR_BIT = 5;
	localparam int ST_PGM_ERR_BIT   = 4;

	typedef enum logic [0:0] {
		KIND_REQUEST = 1'b0,
		KIND_READ    = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		OP_ERASE  = 3'd0,
		OP_WRITE  = 3'd1,
		OP_LOCK   = 3'd2,
		OP_UNLOCK = 3'd3,
		OP_QUERY  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_DONE  = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ERASE_ERR = 2'd1,
		ST_PGM_ERR   = 2'd2
	} status_t;

	// address of a result relative to the burst's halfword address
	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_A    = 2'd1,
		SEL_A1   = 2'd2,
		SEL_A2   = 2'd3
	} asel_t;

	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_ER_STAT   = 7'b0000010,
		PH_ER_CHECK  = 7'b0000100,
		PH_WR_STAT   = 7'b0001000,
		PH_WR_VERIFY = 7'b0010000,
		PH_LK_STAT   = 7'b0100000,
		PH_Q_READ    = 7'b1000000
	} phase_t;

	typedef struct packed {
		act_t        act;
		asel_t       asel;
		logic [15:0] data;
		status_t     status;
		logic [1:0]  lock;
	} entry_t;

	typedef entry_t [MAX_RESULTS-1:0] entries_t;

	function automatic entry_t wr(input logic [15:0] d);
		entry_t e;
		e = '{act: ACT_WRITE, asel: SEL_A, data: d, status: ST_OK, lock: 2'b00};
		return e;
	endfunction

	function automatic entry_t rq(input asel_t s);
		entry_t e;
		e = '{act: ACT_READ, asel: s, data: 16'h0000, status: ST_OK, lock: 2'b00};
		return e;
	endfunction

	function automatic entry_t dn(input status_t st, input logic [1:0] lk);
		entry_t e;
		e = '{act: ACT_DONE, asel: SEL_NONE, data: 16'h0000, status: st, lock: lk};
		return e;
	endfunction

	function automatic entries_t seq5(input logic [15:0] setup, input logic [15:0] conf);
		entries_t e;
		e[0] = wr(CMD_STATUS_CLR);
		e[1] = wr(setup);
		e[2] = wr(conf);
		e[3] = wr(CMD_STATUS_READ);
		e[4] = rq(SEL_A);
		return e;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fcs_decode.sv -----
// ----------------------------------------------------------------------------
// fcs_decode
// Next-state and result-burst decode for one accepted transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_decode #(
	parameter int ADDR_BITS = fcs_pkg::ADDR_BITS_DEF
) (
	input  wire logic                         item_kind,
	input  wire logic [2:0]                   opcode,
	input  wire logic [22:0]                  word_addr,
	input  wire logic [31:0]                  write_data,
	input  wire logic [15:0]                  read_data,
	input  wire fcs_pkg::phase_t              phase,
	input  wire logic [ADDR_BITS-1:0]         base,
	input  wire logic [31:0]                  data,
	input  wire logic                         sh,
	input  wire logic                         pgm_err,
	output fcs_pkg::phase_t                   nxt_phase,
	output logic [ADDR_BITS-1:0]              nxt_base,
	output logic [31:0]                       nxt_data,
	output logic                              nxt_sh,
	output logic                              nxt_pgm_err,
	output logic [fcs_pkg::CNT_W-1:0]         cnt,
	output logic [ADDR_BITS-1:0]              burst_addr,
	output fcs_pkg::entries_t                 ents
);

	logic        busy;
	logic [15:0] cur_half;
	logic [15:0] hi_half;

	function automatic logic [fcs_pkg::CNT_W-1:0] CNT_W_5();
		return fcs_pkg::CNT_W'(fcs_pkg::MAX_RESULTS);
	endfunction

	assign busy     = !read_data[fcs_pkg::ST_READY_BIT];
	assign cur_half = sh ? data[31:16] : data[15:0];
	assign hi_half  = data[31:16];

	always_comb begin
		nxt_phase   = phase;
		nxt_base    = base;
		nxt_data    = data;
		nxt_sh      = sh;
		nxt_pgm_err = pgm_err;
		cnt         = '0;
		ents        = '0;
		if (item_kind == fcs_pkg::KIND_REQUEST) begin
			if (phase == fcs_pkg::PH_IDLE) begin
				nxt_base = ADDR_BITS'({word_addr, 1'b0});
				nxt_sh   = 1'b0;
				case (opcode)
					fcs_pkg::OP_ERASE: begin
						ents      = fcs_pkg::seq5(fcs_pkg::CMD_ERASE_SETUP,
							fcs_pkg::CMD_ERASE_OK);
						cnt       = CNT_W_5();
						nxt_phase = fcs_pkg::PH_ER_STAT;
					end
					fcs_pkg::OP_WRITE: begin
						nxt_data  = write_data;
						ents      = fcs_pkg::seq5(fcs_pkg::CMD_PGM_SETUP,
							write_data[15:0]);
						cnt       = CNT_W_5();
						nxt_phase = fcs_pkg::PH_WR_STAT;
					end
					fcs_pkg::OP_LOCK, fcs_pkg::OP_UNLOCK: begin
						ents      = fcs_pkg::seq5(fcs_pkg::CMD_CFG_SETUP,
							(opcode == fcs_pkg::OP_LOCK) ? fcs_pkg::CMD_LOCK
							: fcs_pkg::CMD_UNLOCK);
						cnt       = CNT_W_5();
						nxt_phase = fcs_pkg::PH_LK_STAT;
					end
					fcs_pkg::OP_QUERY: begin
						ents[0]   = fcs_pkg::wr(fcs_pkg::CMD_READ_CFG);
						ents[1]   = fcs_pkg::rq(fcs_pkg::SEL_A2);
						cnt       = fcs_pkg::CNT_W'(2);
						nxt_phase = fcs_pkg::PH_Q_READ;
					end
					default: begin
						ents[0]   = fcs_pkg::dn(fcs_pkg::ST_PGM_ERR, 2'b00);
						cnt       = fcs_pkg::CNT_W'(1);
						nxt_phase = fcs_pkg::PH_IDLE;
					end
				endcase
			end
		end else begin
			case (phase)
				fcs_pkg::PH_ER_STAT: begin
					if (busy) begin
						ents[0] = fcs_pkg::wr(fcs_pkg::CMD_STATUS_READ);
						ents[1] = fcs_pkg::rq(fcs_pkg::SEL_A);
						cnt     = fcs_pkg::CNT_W'(2);
					end else begin
						ents[0] = fcs_pkg::wr(fcs_pkg::CMD_READ_ARRAY);
						cnt     = fcs_pkg::CNT_W'(2);
						if (read_data[fcs_pkg::ST_ERASE_ERR_BIT]) begin
							ents[1]   = fcs_pkg::dn(fcs_pkg::ST_ERASE_ERR, 2'b00);
							nxt_phase = fcs_pkg::PH_IDLE;
						end else if (sh) begin
							ents[1]   = fcs_pkg::dn(fcs_pkg::ST_OK, 2'b00);
							nxt_phase = fcs_pkg::PH_IDLE;
						end else begin
							ents[1]   = fcs_pkg::rq(fcs_pkg::SEL_A1);
							nxt_phase = fcs_pkg::PH_ER_CHECK;
						end
					end
				end
				fcs_pkg::PH_ER_CHECK: begin
					if (read_data != fcs_pkg::ERASED_HALF) begin
						nxt_sh    = 1'b1;
						ents      = fcs_pkg::seq5(fcs_pkg::CMD_ERASE_SETUP,
							fcs_pkg::CMD_ERASE_OK);
						cnt       = CNT_W_5();
						nxt_phase = fcs_pkg::PH_ER_STAT;
					end else begin
						ents[0]   = fcs_pkg::dn(fcs_pkg::ST_OK, 2'b00);
						cnt       = fcs_pkg::CNT_W'(1);
						nxt_phase = fcs_pkg::PH_IDLE;
					end
				end
				fcs_pkg::PH_WR_STAT: begin
					ents[0] = busy ? fcs_pkg::wr(fcs_pkg::CMD_STATUS_READ)
						: fcs_pkg::wr(fcs_pkg::CMD_READ_ARRAY);
					ents[1] = fcs_pkg::rq(fcs_pkg::SEL_A);
					cnt     = fcs_pkg::CNT_W'(2);
					if (!busy) begin
						nxt_pgm_err = read_data[fcs_pkg::ST_PGM_ERR_BIT];
						nxt_phase   = fcs_pkg::PH_WR_VERIFY;
					end
				end
				fcs_pkg::PH_WR_VERIFY: begin
					if (pgm_err || (read_data != cur_half)) begin
						ents[0]   = fcs_pkg::dn(fcs_pkg::ST_PGM_ERR, 2'b00);
						cnt       = fcs_pkg::CNT_W'(1);
						nxt_phase = fcs_pkg::PH_IDLE;
					end else if (sh) begin
						ents[0]   = fcs_pkg::dn(fcs_pkg::ST_OK, 2'b00);
						cnt       = fcs_pkg::CNT_W'(1);
						nxt_phase = fcs_pkg::PH_IDLE;
					end else begin
						nxt_sh    = 1'b1;
						ents      = fcs_pkg::seq5(fcs_pkg::CMD_PGM_SETUP, hi_half);
						cnt       = CNT_W_5();
						nxt_phase = fcs_pkg::PH_WR_STAT;
					end
				end
				fcs_pkg::PH_LK_STAT: begin
					ents[0]   = fcs_pkg::wr(fcs_pkg::CMD_READ_ARRAY);
					ents[1]   = fcs_pkg::dn(read_data[fcs_pkg::ST_PGM_ERR_BIT]
						? fcs_pkg::ST_PGM_ERR : fcs_pkg::ST_OK, 2'b00);
					cnt       = fcs_pkg::CNT_W'(2);
					nxt_phase = fcs_pkg::PH_IDLE;
				end
				fcs_pkg::PH_Q_READ: begin
					ents[0]   = fcs_pkg::wr(fcs_pkg::CMD_READ_ARRAY);
					ents[1]   = fcs_pkg::dn(fcs_pkg::ST_OK, read_data[1:0]);
					cnt       = fcs_pkg::CNT_W'(2);
					nxt_phase = fcs_pkg::PH_IDLE;
				end
				default: begin
					nxt_phase = fcs_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// every burst addresses the halfword that the next state points at
	assign burst_addr = nxt_base + ADDR_BITS'(nxt_sh);

endmodule

`default_nettype wire

// ----- rtl/core/fcs_burst.sv -----
// ----------------------------------------------------------------------------
// fcs_burst
// Result register: holds one decoded burst; one result a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_burst #(
	parameter int ADDR_BITS = fcs_pkg::ADDR_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire logic [fcs_pkg::CNT_W-1:0]    load_cnt,
	input  wire logic [ADDR_BITS-1:0]         load_addr,
	input  wire fcs_pkg::entries_t            load_ents,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              done_last,
	output logic [1:0]                        action,
	output logic [ADDR_BITS-1:0]              bus_addr,
	output logic [15:0]                       bus_data,
	output logic [1:0]                        status_code,
	output logic [1:0]                        lock_state,
	output logic                              last
);

	logic                        valid_q;
	logic [fcs_pkg::IDX_W-1:0]   idx_q;
	logic [fcs_pkg::CNT_W-1:0]   cnt_q;
	logic [ADDR_BITS-1:0]        addr_q;
	fcs_pkg::entries_t           ents_q;
	fcs_pkg::entry_t             cur;
	logic                        fire;

	assign cur       = ents_q[idx_q];
	assign out_valid = valid_q;
	assign last      = ({1'b0, idx_q} + 1'b1) == {1'b0, cnt_q};
	assign fire      = valid_q && !out_stall;
	assign done_last = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (fire) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_q  <= load_cnt;
			addr_q <= load_addr;
			ents_q <= load_ents;
		end
	end

	always_comb begin
		case (cur.asel)
			fcs_pkg::SEL_A:  bus_addr = addr_q;
			fcs_pkg::SEL_A1: bus_addr = addr_q + ADDR_BITS'(1);
			fcs_pkg::SEL_A2: bus_addr = addr_q + ADDR_BITS'(2);
			default:         bus_addr = '0;
		endcase
	end

	assign action      = cur.act;
	assign bus_data    = cur.data;
	assign status_code = cur.status;
	assign lock_state  = cur.lock;

endmodule

`default_nettype wire

// ----- rtl/core/flash_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// flash_command_sequencer
// Host-side command sequencer for a 16-bit command-set flash.
// ----------------------------------------------------------------------------
// Each transaction (host request or returned bus read data) is decoded in the
// cycle it is accepted and yields a burst of zero to five results (bus writes,
// a bus read request, or the operation's done status), which leave the result
// register one per cycle while out_stall is low. A full command sequence has
// five results. The block takes no new transaction while a burst is still
// being handed out; the next one is accepted in the same cycle as the previous
// burst's last result is taken.
`default_nettype none

module flash_command_sequencer #(
	parameter int ADDR_BITS = fcs_pkg::ADDR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 item_kind,
	input  wire logic [2:0]           opcode,
	input  wire logic [22:0]          word_addr,
	input  wire logic [31:0]          write_data,
	input  wire logic [15:0]          read_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                action,
	output logic [ADDR_BITS-1:0]      bus_addr,
	output logic [15:0]               bus_data,
	output logic [1:0]                status_code,
	output logic [1:0]                lock_state,
	output logic                      last
);

	fcs_pkg::phase_t               phase_q;
	logic [ADDR_BITS-1:0]          base_q;
	logic [31:0]                   data_q;
	logic                          sh_q;
	logic                          pgm_err_q;

	fcs_pkg::phase_t               nxt_phase;
	logic [ADDR_BITS-1:0]          nxt_base;
	logic [31:0]                   nxt_data;
	logic                          nxt_sh;
	logic                          nxt_pgm_err;
	logic [fcs_pkg::CNT_W-1:0]     cnt;
	logic [ADDR_BITS-1:0]          burst_addr;
	fcs_pkg::entries_t             ents;
	logic                          accept;
	logic                          done_last;

	assign in_stall = out_valid && !done_last;
	assign accept   = in_valid && !in_stall;

	fcs_decode #(
		.ADDR_BITS(ADDR_BITS)
	) u_decode (
		.item_kind  (item_kind),
		.opcode     (opcode),
		.word_addr  (word_addr),
		.write_data (write_data),
		.read_data  (read_data),
		.phase      (phase_q),
		.base       (base_q),
		.data       (data_q),
		.sh         (sh_q),
		.pgm_err    (pgm_err_q),
		.nxt_phase  (nxt_phase),
		.nxt_base   (nxt_base),
		.nxt_data   (nxt_data),
		.nxt_sh     (nxt_sh),
		.nxt_pgm_err(nxt_pgm_err),
		.cnt        (cnt),
		.burst_addr (burst_addr),
		.ents       (ents)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fcs_pkg::PH_IDLE;
			base_q    <= '0;
			data_q    <= '0;
			sh_q      <= 1'b0;
			pgm_err_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= nxt_phase;
			base_q    <= nxt_base;
			data_q    <= nxt_data;
			sh_q      <= nxt_sh;
			pgm_err_q <= nxt_pgm_err;
		end
	end

	fcs_burst #(
		.ADDR_BITS(ADDR_BITS)
	) u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept && (cnt != '0)),
		.load_cnt   (cnt),
		.load_addr  (burst_addr),
		.load_ents  (ents),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.done_last  (done_last),
		.action     (action),
		.bus_addr   (bus_addr),
		.bus_data   (bus_data),
		.status_code(status_code),
		.lock_state (lock_state),
		.last       (last)
	);

`ifndef SYNTHESIS
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |=> out_valid)
		else $error("burst dropped before its last result");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == fcs_pkg::ACT_DONE) |-> last)
		else $error("done result not at end of burst");

	a_read_waits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && (action == fcs_pkg::ACT_READ) |-> phase_q != fcs_pkg::PH_IDLE)
		else $error("read request issued with no read pending");
`endif

endmodule

`default_nettype wire
